// ===== design/pfa_pkg.sv =====
package pfa_pkg;

	localparam int SIZE_IN_W = 31;
	localparam int IDX_OUT_W = 4;
	localparam int STATUS_W  = 2;

	localparam logic FIT_FIRST = 1'b0;
	localparam logic FIT_BEST  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_ALLOCATED = 2'd0,
		ST_NO_FIT    = 2'd1,
		ST_APPENDED  = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic {
		CMD_APPEND   = 1'b0,
		CMD_ALLOCATE = 1'b1
	} command_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_WRITE = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	// table port strobes
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

	// selector controls
	typedef struct packed {
		logic clear;
		logic entry_valid;
		logic fit_mode;
	} sel_ctl_t;

endpackage

// ===== design/partition_fit_allocator.sv =====
// Fixed-partition allocator with first-fit and best-fit selection.
// Request channel (req_valid / req_stall) carries one word: command and
// size_value. An append adds a free partition at the end of the table and
// returns its index, or status full. An allocate scans the table and marks
// the chosen partition taken, or returns no fit.
// Response channel (rsp_valid / rsp_stall) returns status and block_index,
// exactly one response word per request word.
// cfg_we / cfg_wdata write fit_mode (0 first fit, 1 best fit); write it only
// while no request is in flight.
// An append or a rejected request goes from accept straight to the done
// state and then into the response register. An allocate reads the partition
// table once per stored partition through a single registered read port,
// then passes a write-back step and a result step before the response.
// One request is in flight at a time; req_stall is high from accept until
// the result moves into the response register.
// The response register lets a new request be accepted while a response
// waits on rsp_stall; a finished result then holds until the register frees.
// Reset clears the partition count, fit_mode and the response valid.
module partition_fit_allocator #(
	parameter int MAX_PARTITIONS = 16,
	parameter int SIZE_BITS      = 31
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic                             cfg_wdata,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic                             command,
	input  logic [pfa_pkg::SIZE_IN_W-1:0]    size_value,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output logic [pfa_pkg::STATUS_W-1:0]     status,
	output logic [pfa_pkg::IDX_OUT_W-1:0]    block_index
);

	localparam int IDX_W   = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
	localparam int CNT_W   = $clog2(MAX_PARTITIONS + 1);
	localparam int ENTRY_W = SIZE_BITS + 1;

	pfa_pkg::state_t   state_q;
	logic              fit_mode_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  scan_idx_q;
	logic [SIZE_BITS-1:0] want_q;
	pfa_pkg::status_t  res_status_q;
	logic [IDX_W-1:0]  res_index_q;
	logic              rsp_valid_q;
	logic [pfa_pkg::STATUS_W-1:0]  status_q;
	logic [pfa_pkg::IDX_OUT_W-1:0] block_index_q;

	logic                 accept;
	logic                 is_append;
	logic                 full;
	logic                 scan_last;
	logic                 rsp_free;
	logic [SIZE_BITS-1:0] want_in;

	pfa_pkg::mem_ctl_t    mem_ctl;
	logic [IDX_W-1:0]     wr_addr;
	logic [ENTRY_W-1:0]   wr_data;
	logic [IDX_W-1:0]     rd_addr;
	logic [ENTRY_W-1:0]   rd_data;

	pfa_pkg::sel_ctl_t    sel_ctl;
	logic                 found;
	logic [IDX_W-1:0]     pick;
	logic [SIZE_BITS-1:0] pick_size;

	assign req_stall = (state_q != pfa_pkg::S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign is_append = (command == pfa_pkg::CMD_APPEND);
	assign want_in   = size_value[SIZE_BITS-1:0];
	assign full      = (count_q == CNT_W'(MAX_PARTITIONS));
	assign scan_last = ((CNT_W'(scan_idx_q) + CNT_W'(1)) == count_q);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// Table accesses are sequenced by state: writes only on append and in
	// write-back, reads only at allocate accept and in the scan, so no same-entry overlap.
	always_comb begin
		mem_ctl = '0;
		wr_addr = count_q[IDX_W-1:0];
		wr_data = {1'b0, want_in};
		rd_addr = '0;
		case (state_q)
			pfa_pkg::S_IDLE: begin
				if (accept && is_append && !full) begin
					mem_ctl.wr_en = 1'b1;
				end
				if (accept && !is_append && count_q != '0) begin
					mem_ctl.rd_en = 1'b1;
				end
			end
			pfa_pkg::S_SCAN: begin
				if (!scan_last) begin
					mem_ctl.rd_en = 1'b1;
					rd_addr       = scan_idx_q + IDX_W'(1);
				end
			end
			pfa_pkg::S_WRITE: begin
				if (found) begin
					mem_ctl.wr_en = 1'b1;
					wr_addr       = pick;
					wr_data       = {1'b1, pick_size};
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		sel_ctl.clear       = (state_q == pfa_pkg::S_IDLE);
		sel_ctl.entry_valid = (state_q == pfa_pkg::S_SCAN);
		sel_ctl.fit_mode    = fit_mode_q;
	end

	pfa_table #(
		.DEPTH  (MAX_PARTITIONS),
		.DATA_W (ENTRY_W)
	) u_table (
		.clk     (clk),
		.ctl     (mem_ctl),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pfa_sel #(
		.IDX_W     (IDX_W),
		.SIZE_BITS (SIZE_BITS)
	) u_sel (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (sel_ctl),
		.want        (want_q),
		.entry_size  (rd_data[SIZE_BITS-1:0]),
		.entry_taken (rd_data[SIZE_BITS]),
		.entry_idx   (scan_idx_q),
		.found       (found),
		.pick        (pick),
		.pick_size   (pick_size)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= pfa_pkg::FIT_FIRST;
		end else if (cfg_we) begin
			fit_mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pfa_pkg::S_IDLE;
			count_q    <= '0;
			scan_idx_q <= '0;
		end else begin
			case (state_q)
				pfa_pkg::S_IDLE: begin
					if (accept) begin
						scan_idx_q <= '0;
						if (is_append) begin
							if (!full) begin
								count_q <= count_q + CNT_W'(1);
							end
							state_q <= pfa_pkg::S_DONE;
						end else if (count_q == '0) begin
							state_q <= pfa_pkg::S_DONE;
						end else begin
							state_q <= pfa_pkg::S_SCAN;
						end
					end
				end
				pfa_pkg::S_SCAN: begin
					if (scan_last) begin
						state_q <= pfa_pkg::S_WRITE;
					end else begin
						scan_idx_q <= scan_idx_q + IDX_W'(1);
					end
				end
				pfa_pkg::S_WRITE: begin
					state_q <= pfa_pkg::S_DONE;
				end
				pfa_pkg::S_DONE: begin
					if (rsp_free) begin
						state_q <= pfa_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= pfa_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pfa_pkg::S_IDLE && accept) begin
			want_q <= want_in;
			if (is_append) begin
				if (full) begin
					res_status_q <= pfa_pkg::ST_FULL;
					res_index_q  <= '0;
				end else begin
					res_status_q <= pfa_pkg::ST_APPENDED;
					res_index_q  <= count_q[IDX_W-1:0];
				end
			end else begin
				res_status_q <= pfa_pkg::ST_NO_FIT;
				res_index_q  <= '0;
			end
		end else if (state_q == pfa_pkg::S_WRITE) begin
			if (found) begin
				res_status_q <= pfa_pkg::ST_ALLOCATED;
				res_index_q  <= pick;
			end else begin
				res_status_q <= pfa_pkg::ST_NO_FIT;
				res_index_q  <= '0;
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == pfa_pkg::S_DONE && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pfa_pkg::S_DONE && rsp_free) begin
			status_q      <= res_status_q;
			block_index_q <= pfa_pkg::IDX_OUT_W'(res_index_q);
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign block_index = block_index_q;

endmodule

// ===== design/pfa_table.sv =====
module pfa_table #(
	parameter int DEPTH  = 16,
	parameter int DATA_W = 32
) (
	input  logic                                     clk,
	input  pfa_pkg::mem_ctl_t                        ctl,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [DATA_W-1:0]                        wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [DATA_W-1:0]                        rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/pfa_sel.sv =====
module pfa_sel #(
	parameter int IDX_W     = 4,
	parameter int SIZE_BITS = 31
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pfa_pkg::sel_ctl_t    ctl,
	input  logic [SIZE_BITS-1:0] want,
	input  logic [SIZE_BITS-1:0] entry_size,
	input  logic                 entry_taken,
	input  logic [IDX_W-1:0]     entry_idx,
	output logic                 found,
	output logic [IDX_W-1:0]     pick,
	output logic [SIZE_BITS-1:0] pick_size
);

	logic                 found_q;
	logic [IDX_W-1:0]     pick_q;
	logic [SIZE_BITS-1:0] pick_size_q;
	logic                 fits;
	logic                 take;

	// first fit keeps the first hit; best fit replaces only on a strictly smaller size
	assign fits = !entry_taken && (entry_size >= want);
	assign take = ctl.entry_valid && fits &&
		(!found_q || (ctl.fit_mode == pfa_pkg::FIT_BEST && entry_size < pick_size_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pick_q      <= entry_idx;
			pick_size_q <= entry_size;
		end
	end

	assign found     = found_q;
	assign pick      = pick_q;
	assign pick_size = pick_size_q;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	localparam int MAX_PARTS   = 16;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		pfa_pkg::status_t                  st;
		logic [pfa_pkg::IDX_OUT_W-1:0]     idx;
	} placement_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_we = 1'b0;
	logic                              cfg_wdata = pfa_pkg::FIT_FIRST;
	logic                              req_valid = 1'b0;
	logic                              req_stall;
	logic                              command = pfa_pkg::CMD_APPEND;
	logic [pfa_pkg::SIZE_IN_W-1:0]     size_value = '0;
	logic                              rsp_valid;
	logic                              rsp_stall = 1'b0;
	logic [pfa_pkg::STATUS_W-1:0]      status;
	logic [pfa_pkg::IDX_OUT_W-1:0]     block_index;

	// shadow of the partition table
	logic [pfa_pkg::SIZE_IN_W-1:0]     part_size [MAX_PARTS];
	logic                              part_taken [MAX_PARTS];
	int                                part_count = 0;
	logic                              fit_sel = pfa_pkg::FIT_FIRST;

	placement_t            pending_placements[$];
	int                    fail_count = 0;
	int                    cycle_count = 0;
	int                    stall_left = 0;
	bit                    idle_en = 1'b1;

	partition_fit_allocator #(
		.MAX_PARTITIONS(MAX_PARTS),
		.SIZE_BITS(pfa_pkg::SIZE_IN_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.command(command),
		.size_value(size_value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.block_index(block_index)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycle_count,
				pending_placements.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic void note_fault(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// Applies one request word to the shadow table and returns its result.
	function automatic placement_t predict_placement(input pfa_pkg::command_t cmd,
			input logic [pfa_pkg::SIZE_IN_W-1:0] sz);
		placement_t res;
		int pick;
		res.st = pfa_pkg::ST_NO_FIT;
		res.idx = '0;
		pick = -1;
		if (cmd == pfa_pkg::CMD_APPEND) begin
			if (part_count >= MAX_PARTS) begin
				res.st = pfa_pkg::ST_FULL;
			end else begin
				part_size[part_count] = sz;
				part_taken[part_count] = 1'b0;
				res.st = pfa_pkg::ST_APPENDED;
				res.idx = pfa_pkg::IDX_OUT_W'(part_count);
				part_count++;
			end
		end else begin
			for (int i = 0; i < part_count; i++) begin
				if (!part_taken[i] && part_size[i] >= sz) begin
					if (pick < 0)
						pick = i;
					else if (fit_sel == pfa_pkg::FIT_BEST && part_size[i] < part_size[pick])
						pick = i;
					if (fit_sel == pfa_pkg::FIT_FIRST)
						break;
				end
			end
			if (pick >= 0) begin
				part_taken[pick] = 1'b1;
				res.st = pfa_pkg::ST_ALLOCATED;
				res.idx = pfa_pkg::IDX_OUT_W'(pick);
			end
		end
		return res;
	endfunction

	// Leaves valid high on return; an idle step in a later call, or write_fit_mode, lowers it.
	task automatic send_word(input pfa_pkg::command_t cmd,
			input logic [pfa_pkg::SIZE_IN_W-1:0] sz);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_valid  <= 1'b1;
		command    <= cmd;
		size_value <= sz;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pending_placements.push_back(predict_placement(cmd, sz));
	endtask

	task automatic wait_drained();
		while (pending_placements.size() != 0) @(posedge clk);
	endtask

	task automatic write_fit_mode(input logic mode);
		req_valid <= 1'b0;
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
		fit_sel = mode;
	endtask

	// response side: random stall bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			if (stall_left == 0)
				rsp_stall <= 1'b0;
		end else if (idle_en && arst_n && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 6);
			rsp_stall <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_word
		placement_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_placements.size() == 0) begin
				note_fault($sformatf("unexpected word: status %0d index %0d",
					status, block_index));
			end else begin
				want = pending_placements.pop_front();
				if (status !== want.st || block_index !== want.idx)
					note_fault($sformatf("mismatch: exp status %0d index %0d, got status %0d index %0d",
						want.st, want.idx, status, block_index));
			end
		end
	end

	function automatic logic [pfa_pkg::SIZE_IN_W-1:0] append_size();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 3))
			0: return pfa_pkg::SIZE_IN_W'($urandom_range(0, 15));
			1: return {pfa_pkg::SIZE_IN_W{1'b1}} - pfa_pkg::SIZE_IN_W'($urandom_range(0, 3));
			default: return r[pfa_pkg::SIZE_IN_W-1:0];
		endcase
	endfunction

	// In one of three calls with a free partition, a near-hit around its size, so both modes see real choices.
	function automatic logic [pfa_pkg::SIZE_IN_W-1:0] request_size();
		int free_idx[$];
		logic [pfa_pkg::SIZE_IN_W-1:0] base;
		logic [31:0] r;
		r = $urandom;
		for (int i = 0; i < part_count; i++)
			if (!part_taken[i])
				free_idx.push_back(i);
		if (free_idx.size() != 0 && $urandom_range(0, 2) == 0) begin
			base = part_size[free_idx[$urandom_range(0, free_idx.size() - 1)]];
			case ($urandom_range(0, 2))
				0: if (base != '0) base = base - pfa_pkg::SIZE_IN_W'(1);
				1: if (base != '1) base = base + pfa_pkg::SIZE_IN_W'(1);
				default: ;
			endcase
			return base;
		end
		if ($urandom_range(0, 7) == 0)
			return {pfa_pkg::SIZE_IN_W{1'b1}};
		return r[pfa_pkg::SIZE_IN_W-1:0];
	endfunction

	task automatic test_empty_table();
		write_fit_mode(pfa_pkg::FIT_FIRST);
		send_word(pfa_pkg::CMD_ALLOCATE, '0);
		send_word(pfa_pkg::CMD_ALLOCATE, '1);
	endtask

	task automatic test_first_fit();
		send_word(pfa_pkg::CMD_APPEND, 31'd100);
		send_word(pfa_pkg::CMD_APPEND, 31'd50);
		send_word(pfa_pkg::CMD_APPEND, '1);
		send_word(pfa_pkg::CMD_APPEND, '0);
		send_word(pfa_pkg::CMD_APPEND, 31'd200);
		send_word(pfa_pkg::CMD_ALLOCATE, 31'd60);
		send_word(pfa_pkg::CMD_ALLOCATE, '1);
		send_word(pfa_pkg::CMD_ALLOCATE, 31'd1000);
	endtask

	// equal sizes at 5 and 6: lower index must win
	task automatic test_best_fit();
		write_fit_mode(pfa_pkg::FIT_BEST);
		send_word(pfa_pkg::CMD_APPEND, 31'd70);
		send_word(pfa_pkg::CMD_APPEND, 31'd70);
		send_word(pfa_pkg::CMD_APPEND, 31'd150);
		send_word(pfa_pkg::CMD_ALLOCATE, 31'd60);
		send_word(pfa_pkg::CMD_ALLOCATE, '0);
	endtask

	task automatic test_table_full();
		while (part_count < MAX_PARTS)
			send_word(pfa_pkg::CMD_APPEND, append_size());
		send_word(pfa_pkg::CMD_APPEND, 31'd5);
	endtask

	task automatic test_random_traffic();
		for (int ph = 0; ph < 6; ph++) begin
			write_fit_mode(ph == 0 ? pfa_pkg::FIT_FIRST : ph == 1 ? pfa_pkg::FIT_BEST :
				1'($urandom_range(0, 1)));
			for (int k = 0; k < 250; k++) begin
				if ($urandom_range(0, 7) == 0)
					send_word(pfa_pkg::CMD_APPEND, append_size());
				else
					send_word(pfa_pkg::CMD_ALLOCATE, request_size());
			end
		end
	endtask

	task automatic test_quiet_tail();
		write_fit_mode(1'($urandom_range(0, 1)));
		idle_en = 1'b0;
		for (int k = 0; k < 250; k++) begin
			if ($urandom_range(0, 1) == 0)
				send_word(pfa_pkg::CMD_APPEND, append_size());
			else
				send_word(pfa_pkg::CMD_ALLOCATE, request_size());
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_table();
		test_first_fit();
		test_best_fit();
		test_table_full();
		test_random_traffic();
		test_quiet_tail();
		req_valid <= 1'b0;
		wait_drained();
		repeat (30) @(posedge clk);
		if (fail_count == 0 && pending_placements.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
